@@ src/gwwlr_pkg.sv @@
// ----------------------------------------------------------------------------
// gwwlr_pkg
// Shared types and constants of the greedy word wrap line ring core: channel
// payloads, the command passed from front to back and the sequencer states.
// ----------------------------------------------------------------------------
package gwwlr_pkg;

  localparam int MAX_COLS  = 38;
  localparam int MAX_ROWS  = 32;
  localparam int CMD_DEPTH = 2;

  localparam int COL_W   = 6;
  localparam int SLOT_W  = 5;
  localparam int ADDR_W  = $clog2(MAX_COLS);
  localparam int CNT_W   = 16;
  localparam int CFG_W   = 6;
  localparam int QPTR_W  = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int QCNT_W  = $clog2(CMD_DEPTH + 1);

  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_LF         = 8'h0A;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_EOL        = 8'h00;

  localparam logic FUNC_TEXT = 1'b0;
  localparam logic FUNC_END  = 1'b1;

  localparam logic REG_LINE_COLS = 1'b0;
  localparam logic REG_RING_ROWS = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] text_byte;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] row_slot;
    logic [COL_W-1:0]  column;
    logic [7:0]        cell_char;
    logic [CNT_W-1:0]  lines_total;
    logic [CNT_W-1:0]  first_visible;
    logic              last;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_CHAR,
    OP_SPACE,
    OP_NEWLINE,
    OP_END,
    OP_SKIP
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] text_byte;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_NORM,
    BK_WRAP,
    BK_READ,
    BK_EMIT,
    BK_POST,
    BK_CURSOR
  } bk_state_t;

endpackage

@@ src/gwwlr_front.sv @@
// ----------------------------------------------------------------------------
// gwwlr_front
// Input stage: accepts text items, classifies them into commands and holds
// one command until the queue takes it.
// ----------------------------------------------------------------------------
module gwwlr_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  gwwlr_pkg::in_item_t in_data,
  output logic               push,
  output gwwlr_pkg::cmd_t    push_cmd,
  input  logic               queue_full
);
  import gwwlr_pkg::*;

  logic hold_valid;
  logic hold_valid_next;
  cmd_t hold_cmd;
  cmd_t cmd_decoded;
  logic accept;

  assign in_stall = hold_valid && queue_full;
  assign accept   = in_valid && !in_stall;
  assign push     = hold_valid;
  assign push_cmd = hold_cmd;

  always_comb begin
    cmd_decoded.text_byte = in_data.text_byte;
    cmd_decoded.op = OP_CHAR;
    if (in_data.func == FUNC_END) begin
      cmd_decoded.op = OP_END;
    end else begin
      unique case (in_data.text_byte)
        CH_CR:    cmd_decoded.op = OP_SKIP;
        CH_LF:    cmd_decoded.op = OP_NEWLINE;
        CH_SPACE: cmd_decoded.op = OP_SPACE;
        default:  cmd_decoded.op = OP_CHAR;
      endcase
    end
  end

  always_comb begin
    hold_valid_next = hold_valid;
    if (hold_valid && !queue_full) begin
      hold_valid_next = 1'b0;
    end
    if (accept) begin
      hold_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= hold_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_cmd <= cmd_decoded;
    end
  end

endmodule

@@ src/gwwlr_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// gwwlr_cmd_fifo
// Short command queue between the front and the back sequencer.
// ----------------------------------------------------------------------------
module gwwlr_cmd_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  gwwlr_pkg::cmd_t push_cmd,
  output logic            full,
  input  logic            pop,
  output gwwlr_pkg::cmd_t pop_cmd,
  output logic            empty
);
  import gwwlr_pkg::*;

  cmd_t              entries [CMD_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == QCNT_W'(CMD_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

@@ src/gwwlr_back.sv @@
// ----------------------------------------------------------------------------
// gwwlr_back
// Layout sequencer: keeps the word buffer and line state, places words with
// greedy wrap and drives cell writes through a registered output stage.
// ----------------------------------------------------------------------------
module gwwlr_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [gwwlr_pkg::CFG_W-1:0] cols,
  input  logic [gwwlr_pkg::CFG_W-1:0] rows,
  input  logic                        cmd_empty,
  input  gwwlr_pkg::cmd_t             pop_cmd,
  output logic                        cmd_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output gwwlr_pkg::out_item_t        out_data
);
  import gwwlr_pkg::*;

  bk_state_t         state;
  bk_state_t         state_next;
  cmd_t              cmd;
  cmd_t              cmd_next;
  logic [COL_W-1:0]  wl;
  logic [COL_W-1:0]  wl_next;
  logic [COL_W-1:0]  col;
  logic [COL_W-1:0]  col_next;
  logic              hard;
  logic              hard_next;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] slot_next;
  logic [CNT_W-1:0]  line_count;
  logic [CNT_W-1:0]  line_count_next;
  logic [ADDR_W-1:0] j;
  logic [ADDR_W-1:0] j_next;
  logic [7:0]        rdata;
  logic              out_valid_next;
  out_item_t         out_data_next;

  logic [7:0]        word_mem [MAX_COLS];
  logic              mem_we;
  logic              rd_en;

  logic              emit;
  out_item_t         emit_data;
  logic              emit_ok;
  logic              slot_over;
  logic              char_full;
  logic              col_full;
  logic              wrap_need;
  logic              space_fits;
  logic              place_end;
  logic              place_last;
  logic [SLOT_W-1:0] slot_adv;
  logic [CNT_W-1:0]  line_inc;
  logic [CNT_W-1:0]  first_vis;
  logic [COL_W:0]    col_wl_sum;
  logic [COL_W:0]    col_plus1;

  assign emit_ok    = !out_valid || !out_stall;
  assign slot_over  = {1'b0, slot} >= rows;
  assign char_full  = wl >= cols;
  assign col_full   = col >= cols;
  assign col_wl_sum = {1'b0, col} + {1'b0, wl};
  assign col_plus1  = {1'b0, col} + 1'b1;
  assign wrap_need  = (col != '0) && (col_wl_sum > {1'b0, cols});
  assign space_fits = (col < cols) && ((col != '0) || hard);
  assign place_end  = (COL_W'(j) + 1'b1) == wl;
  assign place_last = (cmd.op == OP_CHAR) ||
                      ((cmd.op == OP_SPACE) && !(col_plus1 < {1'b0, cols}));
  assign slot_adv   = (({1'b0, slot} + 1'b1) == rows) ? '0 : slot + 1'b1;
  assign line_inc   = (line_count == '1) ? line_count : line_count + 1'b1;
  assign first_vis  = (line_inc > CNT_W'(rows)) ? line_inc - CNT_W'(rows) : '0;

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!cmd_empty) state_next = BK_NORM;
      end
      BK_NORM: begin
        if (!slot_over) begin
          if (cmd.op == OP_SKIP) state_next = BK_IDLE;
          else if (cmd.op == OP_CHAR && !char_full) state_next = BK_IDLE;
          else state_next = BK_WRAP;
        end
      end
      BK_WRAP: begin
        if (wl == '0) state_next = BK_POST;
        else if (!wrap_need || emit_ok) state_next = BK_READ;
      end
      BK_READ: state_next = BK_EMIT;
      BK_EMIT: begin
        if (emit_ok) state_next = place_end ? BK_POST : BK_READ;
      end
      BK_POST: begin
        unique case (cmd.op)
          OP_CHAR:    state_next = BK_IDLE;
          OP_SPACE:   if (!space_fits || emit_ok) state_next = BK_IDLE;
          OP_NEWLINE: if (emit_ok) state_next = BK_IDLE;
          OP_END:     if (emit_ok && !col_full) state_next = BK_CURSOR;
          default:    state_next = BK_IDLE;
        endcase
      end
      BK_CURSOR: begin
        if (emit_ok) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_next        = cmd;
    wl_next         = wl;
    col_next        = col;
    hard_next       = hard;
    slot_next       = slot;
    line_count_next = line_count;
    j_next          = j;
    mem_we          = 1'b0;
    rd_en           = 1'b0;
    cmd_pop         = 1'b0;
    emit            = 1'b0;
    emit_data       = '0;
    emit_data.row_slot = slot;
    emit_data.column   = col;
    emit_data.cell_char = CH_EOL;
    unique case (state)
      BK_IDLE: begin
        cmd_pop  = !cmd_empty;
        cmd_next = pop_cmd;
      end
      BK_NORM: begin
        j_next = '0;
        if (slot_over) begin
          slot_next = SLOT_W'({1'b0, slot} - rows);
        end else if (cmd.op == OP_CHAR && !char_full) begin
          mem_we  = 1'b1;
          wl_next = wl + 1'b1;
        end
      end
      BK_WRAP: begin
        if (wl != '0 && wrap_need && emit_ok) begin
          emit            = 1'b1;
          slot_next       = slot_adv;
          line_count_next = line_inc;
          col_next        = '0;
          hard_next       = 1'b0;
        end
      end
      BK_READ: rd_en = 1'b1;
      BK_EMIT: begin
        if (emit_ok) begin
          emit                = 1'b1;
          emit_data.cell_char = rdata;
          emit_data.last      = place_end && place_last;
          col_next            = col + 1'b1;
          j_next              = j + 1'b1;
          if (place_end) wl_next = '0;
        end
      end
      BK_POST: begin
        unique case (cmd.op)
          OP_CHAR: begin
            mem_we  = 1'b1;
            wl_next = wl + 1'b1;
          end
          OP_SPACE: begin
            if (space_fits && emit_ok) begin
              emit                = 1'b1;
              emit_data.cell_char = CH_SPACE;
              emit_data.last      = 1'b1;
              col_next            = col + 1'b1;
            end
          end
          OP_NEWLINE: begin
            if (emit_ok) begin
              emit            = 1'b1;
              emit_data.last  = 1'b1;
              slot_next       = slot_adv;
              line_count_next = line_inc;
              col_next        = '0;
              hard_next       = 1'b1;
            end
          end
          OP_END: begin
            if (emit_ok) begin
              emit = 1'b1;
              if (col_full) begin
                slot_next       = slot_adv;
                line_count_next = line_inc;
                col_next        = '0;
                hard_next       = 1'b0;
              end else begin
                emit_data.cell_char = CH_UNDERSCORE;
                col_next            = col + 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      BK_CURSOR: begin
        if (emit_ok) begin
          emit                    = 1'b1;
          emit_data.last          = 1'b1;
          emit_data.lines_total   = line_inc;
          emit_data.first_visible = first_vis;
          wl_next                 = '0;
          col_next                = '0;
          hard_next               = 1'b1;
          slot_next               = '0;
          line_count_next         = '0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    out_data_next  = out_data;
    if (emit) begin
      out_valid_next = 1'b1;
      out_data_next  = emit_data;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_IDLE;
      wl         <= '0;
      col        <= '0;
      hard       <= 1'b1;
      slot       <= '0;
      line_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      wl         <= wl_next;
      col        <= col_next;
      hard       <= hard_next;
      slot       <= slot_next;
      line_count <= line_count_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd      <= cmd_next;
    j        <= j_next;
    out_data <= out_data_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      word_mem[wl[ADDR_W-1:0]] <= cmd.text_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= word_mem[j];
    end
  end

endmodule

@@ src/greedy_word_wrap_line_ring_core.sv @@
// ----------------------------------------------------------------------------
// greedy_word_wrap_line_ring_core
// Greedy word wrap of a text stream into a ring of display lines, emitting
// one cell write per result.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_data   (func, text_byte)
//   out      output     out_valid/ out_stall out_data  (cell write, totals)
//   cfg      input      cfg_we               cfg_index, cfg_data
//
// Each placed character takes a word buffer read, then an output write.
// Line ends, spaces and the cursor are one output write each; after the ring
// shrinks, slot normalization subtracts the ring size from the slot, one
// subtraction per cycle. Reset is synchronous; there is no clearing pass, the
// word buffer is only read after it is written. A stalled output holds the
// sequencer; the front and the command queue keep accepting until the queue
// fills.
// ----------------------------------------------------------------------------
module greedy_word_wrap_line_ring_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  gwwlr_pkg::in_item_t         in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output gwwlr_pkg::out_item_t        out_data,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [gwwlr_pkg::CFG_W-1:0] cfg_data
);
  import gwwlr_pkg::*;

  logic [CFG_W-1:0] cols_eff;
  logic [CFG_W-1:0] rows_eff;
  logic [CFG_W-1:0] cols_clamped;
  logic [CFG_W-1:0] rows_clamped;

  logic push;
  cmd_t push_cmd;
  logic queue_full;
  logic cmd_pop;
  cmd_t pop_cmd;
  logic cmd_empty;

  always_comb begin
    if (cfg_data == '0) cols_clamped = CFG_W'(1);
    else if (cfg_data > CFG_W'(MAX_COLS)) cols_clamped = CFG_W'(MAX_COLS);
    else cols_clamped = cfg_data;
    if (cfg_data == '0) rows_clamped = CFG_W'(1);
    else if (cfg_data > CFG_W'(MAX_ROWS)) rows_clamped = CFG_W'(MAX_ROWS);
    else rows_clamped = cfg_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_eff <= CFG_W'(MAX_COLS);
      rows_eff <= CFG_W'(MAX_ROWS);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LINE_COLS: cols_eff <= cols_clamped;
        REG_RING_ROWS: rows_eff <= rows_clamped;
        default: ;
      endcase
    end
  end

  gwwlr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .push       (push),
    .push_cmd   (push_cmd),
    .queue_full (queue_full)
  );

  gwwlr_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (queue_full),
    .pop      (cmd_pop),
    .pop_cmd  (pop_cmd),
    .empty    (cmd_empty)
  );

  gwwlr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cols      (cols_eff),
    .rows      (rows_eff),
    .cmd_empty (cmd_empty),
    .pop_cmd   (pop_cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_totals_only_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.lines_total != '0) |-> out_data.last)
    else $error("line totals reported on a non-final cell write");

  a_first_below_total: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.last && (out_data.lines_total != '0) |->
      out_data.first_visible < out_data.lines_total)
    else $error("first visible line not below line total");

  a_column_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.column <= COL_W'(MAX_COLS))
    else $error("cell write column beyond line width");

endmodule

@@ dv/tb_greedy_word_wrap_line_ring_core.sv @@
// ----------------------------------------------------------------------------
// tb_greedy_word_wrap_line_ring_core
// Self-checking bench for the greedy word wrap line ring core. A directed
// table covers reset, ignored bytes, hard and soft breaks, clamped register
// values, ring shrink and mid-line column shrink. Random text phases follow
// under changing line widths and ring sizes. A closing phase then runs with
// no idling. Every cell write is checked against a behavioral model of the
// wrap, or against literal cells for the directed steps that carry them.
// ----------------------------------------------------------------------------
module tb_greedy_word_wrap_line_ring_core;
  timeunit 1ns;
  timeprecision 1ps;
  import gwwlr_pkg::*;

  typedef struct packed {
    logic       is_cfg;
    logic       func;
    logic [7:0] ch;
    logic       idx;
    logic [5:0] val;
    logic       lit;
    logic [1:0] n_lit;
    out_item_t  lit0;
    out_item_t  lit1;
  } step_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           in_valid = 1'b0;
  logic           in_stall;
  in_item_t       in_data = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  out_item_t      out_data;
  logic           cfg_we = 1'b0;
  logic           cfg_index = REG_LINE_COLS;
  logic [CFG_W-1:0] cfg_data = '0;

  int stall_pct = 0;
  int gap_pct = 0;
  int stall_left = 0;
  int mismatches = 0;

  out_item_t cells_due[$];
  out_item_t item_cells[$];

  // wrap model state
  logic [7:0]  word_buf [MAX_COLS];
  logic [5:0]  word_len;
  logic [5:0]  cur_col;
  logic        hard_start;
  logic [4:0]  cur_slot;
  logic [15:0] line_cnt;
  logic [5:0]  cols_reg;
  logic [5:0]  rows_reg;

  greedy_word_wrap_line_ring_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int cols_used();
    if (cols_reg == 0) return 1;
    if (cols_reg > MAX_COLS) return MAX_COLS;
    return int'(cols_reg);
  endfunction

  function automatic int rows_used();
    if (rows_reg == 0) return 1;
    if (rows_reg > MAX_ROWS) return MAX_ROWS;
    return int'(rows_reg);
  endfunction

  function automatic void clear_layout();
    word_len = '0;
    cur_col = '0;
    hard_start = 1'b1;
    cur_slot = '0;
    line_cnt = '0;
  endfunction

  function automatic void put_cell(logic [5:0] col, logic [7:0] ch);
    out_item_t c;
    c = '0;
    c.row_slot = cur_slot;
    c.column = col;
    c.cell_char = ch;
    item_cells.push_back(c);
  endfunction

  function automatic void break_line(logic wrapped);
    put_cell(cur_col, CH_EOL);
    cur_slot = SLOT_W'((int'(cur_slot) + 1) % rows_used());
    if (line_cnt != 16'hFFFF) line_cnt = line_cnt + 16'd1;
    cur_col = '0;
    hard_start = !wrapped;
  endfunction

  function automatic void flush_word();
    if (word_len == 0) return;
    if (cur_col > 0 && int'(cur_col) + int'(word_len) > cols_used()) break_line(1'b1);
    for (int j = 0; j < int'(word_len); j++) begin
      put_cell(cur_col, word_buf[j]);
      cur_col = cur_col + 6'd1;
    end
    word_len = '0;
  endfunction

  function automatic void wrap_step(in_item_t it);
    int lines;
    int first;
    out_item_t tail;
    item_cells.delete();
    if (int'(cur_slot) >= rows_used()) cur_slot = SLOT_W'(int'(cur_slot) % rows_used());
    if (it.func == FUNC_TEXT) begin
      if (it.text_byte == CH_LF) begin
        flush_word();
        break_line(1'b0);
      end else if (it.text_byte == CH_SPACE) begin
        flush_word();
        if (int'(cur_col) < cols_used() && (cur_col > 0 || hard_start)) begin
          put_cell(cur_col, CH_SPACE);
          cur_col = cur_col + 6'd1;
        end
      end else if (it.text_byte != CH_CR) begin
        if (int'(word_len) >= cols_used()) flush_word();
        if (word_len < MAX_COLS) begin
          word_buf[word_len] = it.text_byte;
          word_len = word_len + 6'd1;
        end
      end
    end else begin
      flush_word();
      if (int'(cur_col) >= cols_used()) break_line(1'b1);
      put_cell(cur_col, CH_UNDERSCORE);
      cur_col = cur_col + 6'd1;
      put_cell(cur_col, CH_EOL);
      lines = int'(line_cnt) + 1;
      if (lines > 65535) lines = 65535;
      first = (lines > rows_used()) ? lines - rows_used() : 0;
      tail = item_cells.pop_back();
      tail.lines_total = CNT_W'(lines);
      tail.first_visible = CNT_W'(first);
      item_cells.push_back(tail);
      clear_layout();
    end
    if (item_cells.size() > 0) begin
      tail = item_cells.pop_back();
      tail.last = 1'b1;
      item_cells.push_back(tail);
    end
  endfunction

  // check each cell write transfer against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (cells_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected cell write: slot=%0d col=%0d ch=%h lines=%0d first=%0d last=%b",
                   out_data.row_slot, out_data.column, out_data.cell_char,
                   out_data.lines_total, out_data.first_visible, out_data.last);
      end else begin
        want = cells_due.pop_front();
        if (out_data.row_slot !== want.row_slot || out_data.column !== want.column ||
            out_data.cell_char !== want.cell_char ||
            out_data.lines_total !== want.lines_total ||
            out_data.first_visible !== want.first_visible || out_data.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("cell mismatch: exp slot=%0d col=%0d ch=%h lines=%0d first=%0d last=%b",
                     want.row_slot, want.column, want.cell_char, want.lines_total,
                     want.first_visible, want.last,
                     " got slot=%0d col=%0d ch=%h lines=%0d first=%0d last=%b",
                     out_data.row_slot, out_data.column, out_data.cell_char,
                     out_data.lines_total, out_data.first_visible, out_data.last);
        end
      end
    end
  end

  // random stall bursts on the result side
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(10);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_item(in_item_t it);
    int gap;
    gap = 0;
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) gap = $urandom_range(1, 11);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic feed(logic func, logic [7:0] ch);
    in_item_t it;
    it.func = func;
    it.text_byte = ch;
    send_item(it);
    wrap_step(it);
    foreach (item_cells[k]) cells_due.push_back(item_cells[k]);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (cells_due.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic set_reg(logic idx, logic [5:0] val);
    wait_idle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_LINE_COLS) cols_reg = val;
    else rows_reg = val;
  endtask

  // mostly words and separators, with some raw bytes mixed in
  task automatic random_text(int n_items);
    int sent;
    int r;
    int len;
    logic [7:0] ch;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(99);
      if (r < 60) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(1, cols_used() + 6) : $urandom_range(1, 8);
        for (int j = 0; j < len; j++) begin
          ch = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(8'h21, 8'h7E));
          feed(FUNC_TEXT, ch);
          if (ch != CH_CR) sent++;
        end
      end else if (r < 80) begin
        feed(FUNC_TEXT, CH_SPACE);
        sent++;
      end else if (r < 88) begin
        feed(FUNC_TEXT, CH_LF);
        sent++;
      end else if (r < 92) begin
        feed(FUNC_TEXT, CH_CR);
      end else if (r < 95) begin
        feed(FUNC_END, 8'($urandom_range(255)));
        sent++;
      end else begin
        ch = 8'($urandom_range(255));
        feed(FUNC_TEXT, ch);
        if (ch != CH_CR) sent++;
      end
    end
  endtask

  function automatic step_t txt(logic [7:0] ch);
    step_t s;
    s = '0;
    s.func = FUNC_TEXT;
    s.ch = ch;
    return s;
  endfunction

  function automatic step_t fin();
    step_t s;
    s = '0;
    s.func = FUNC_END;
    return s;
  endfunction

  function automatic step_t reg_wr(logic idx, logic [5:0] val);
    step_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.val = val;
    return s;
  endfunction

  initial begin
    step_t script[$];
    step_t s;
    in_item_t it;
    logic [5:0] phase_cols [10];
    logic [5:0] phase_rows [10];

    for (int j = 0; j < MAX_COLS; j++) word_buf[j] = '0;
    clear_layout();
    cols_reg = 6'd38;
    rows_reg = 6'd32;

    // end of text right after reset: cursor at the origin, one line
    s = fin();
    s.lit = 1'b1;
    s.n_lit = 2'd2;
    s.lit0 = '{row_slot: '0, column: '0, cell_char: CH_UNDERSCORE,
               lines_total: '0, first_visible: '0, last: 1'b0};
    s.lit1 = '{row_slot: '0, column: 6'd1, cell_char: CH_EOL,
               lines_total: 16'd1, first_visible: '0, last: 1'b1};
    script.push_back(s);
    s = txt(CH_CR);
    s.lit = 1'b1;
    script.push_back(s);
    s = txt(8'hFF);
    s.lit = 1'b1;
    script.push_back(s);
    script.push_back(txt(8'h00));
    script.push_back(txt(CH_LF));
    script.push_back(txt(CH_SPACE));
    script.push_back(txt("b"));
    script.push_back(txt(CH_SPACE));
    script.push_back(reg_wr(REG_LINE_COLS, 6'd3));
    script.push_back(txt("x"));
    script.push_back(txt("y"));
    script.push_back(txt("z"));
    script.push_back(txt("w"));
    script.push_back(txt(CH_SPACE));
    script.push_back(txt(CH_LF));
    script.push_back(reg_wr(REG_LINE_COLS, 6'd0));
    script.push_back(txt("a"));
    script.push_back(txt("b"));
    script.push_back(txt(CH_SPACE));
    script.push_back(reg_wr(REG_LINE_COLS, 6'd63));
    script.push_back(reg_wr(REG_RING_ROWS, 6'd1));
    script.push_back(txt("k"));
    script.push_back(txt("m"));
    script.push_back(txt(CH_SPACE));
    script.push_back(reg_wr(REG_LINE_COLS, 6'd2));
    script.push_back(txt(CH_SPACE));
    script.push_back(txt("q"));
    script.push_back(fin());
    script.push_back(reg_wr(REG_RING_ROWS, 6'd0));
    script.push_back(reg_wr(REG_RING_ROWS, 6'd63));
    script.push_back(reg_wr(REG_LINE_COLS, 6'd38));
    script.push_back(reg_wr(REG_RING_ROWS, 6'd32));
    script.push_back(txt(CH_LF));
    script.push_back(fin());

    phase_cols = '{6'd1, 6'd38, 6'd2, 6'd63, 6'd0, 6'd5, 6'd12, 6'd20, 6'd3, 6'd38};
    phase_rows = '{6'd32, 6'd1, 6'd63, 6'd0, 6'd3, 6'd2, 6'd7, 6'd5, 6'd32, 6'd1};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    stall_pct = 20;
    gap_pct = 20;
    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        set_reg(script[i].idx, script[i].val);
      end else if (script[i].lit) begin
        it.func = script[i].func;
        it.text_byte = script[i].ch;
        send_item(it);
        wrap_step(it);
        if (script[i].n_lit > 0) cells_due.push_back(script[i].lit0);
        if (script[i].n_lit > 1) cells_due.push_back(script[i].lit1);
      end else begin
        feed(script[i].func, script[i].ch);
      end
    end

    for (int p = 0; p < 10; p++) begin
      stall_pct = (p % 3 == 0) ? 0 : $urandom_range(5, 40);
      gap_pct = (p % 4 == 1) ? 0 : $urandom_range(5, 40);
      set_reg(REG_LINE_COLS, (p >= 7) ? 6'($urandom_range(63)) : phase_cols[p]);
      set_reg(REG_RING_ROWS, (p >= 8) ? 6'($urandom_range(63)) : phase_rows[p]);
      random_text(36);
      feed(FUNC_END, 8'($urandom_range(255)));
    end

    // flat out to the end
    stall_pct = 0;
    gap_pct = 0;
    set_reg(REG_LINE_COLS, 6'd38);
    set_reg(REG_RING_ROWS, 6'd7);
    random_text(20);
    feed(FUNC_END, 8'h00);

    @(negedge clk);
    in_valid <= 1'b0;
    while (cells_due.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (mismatches == 0 && cells_due.size() == 0) begin
      $display("greedy_word_wrap_line_ring_core test passed");
    end else begin
      $display("greedy_word_wrap_line_ring_core test failed");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("greedy_word_wrap_line_ring_core test failed");
    $finish;
  end

endmodule
